// File: src/pidc_pkg.sv
// Shared types and constants for the clamped PID controller.
`default_nettype none

package pidc_pkg;

    // Fixed field widths and fixed-point scaling
    localparam int ELAPSED_W   = 16;
    localparam int GAIN_W      = 32;
    localparam int DRIVE_W     = 16;
    localparam int DRIVE_SHIFT = 14;
    localparam int DERIV_FRAC  = 20;
    localparam int CHUNK_W     = 32;
    localparam int TERM_W      = 62;
    localparam int SUM_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [63:0]               TERM_LIMIT = 64'h1000_0000_0000_0000;
    localparam logic signed [SUM_W-1:0]   ONE_UNITS  = 64'sd268435456;
    localparam logic signed [DRIVE_W-1:0] DRIVE_ONE  = 16'sd16384;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INC,
        S_INTEG,
        S_IMAG,
        S_MUL,
        S_ACC,
        S_TERM,
        S_DWAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } t_term;

    typedef struct packed {
        logic  load_in;
        logic  calc_err;
        logic  calc_inc;
        logic  calc_integ;
        logic  calc_imag;
        logic  mul;
        logic  acc_add;
        logic  acc_first;
        logic  term_add;
        logic  out_load;
        logic  out_zero;
        t_term term;
    } t_cmd;

    typedef struct packed {
        logic dt_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: src/pidc_divider.sv
// Restoring serial divider, one quotient bit per cycle, 16-bit divisor.
`default_nettype none

module pidc_divider
    import pidc_pkg::*;
#(
    parameter int NUM_W = 38
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_W-1:0]     i_numer,
    input  wire logic [ELAPSED_W-1:0] i_denom,
    output logic                      o_done,
    output logic [NUM_W-1:0]          o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [ELAPSED_W-1:0] r_rem;
    logic [ELAPSED_W-1:0] r_den;
    logic [NUM_W-1:0]     r_quo;

    logic [ELAPSED_W:0]   rem_sh;
    logic                 q_bit;
    logic [ELAPSED_W:0]   rem_sub;
    logic [ELAPSED_W-1:0] n_rem;

    assign rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};
    // remainder stays below the divisor, so it fits in 16 bits
    assign n_rem   = q_bit ? rem_sub[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_numer;
            r_rem <= '0;
            r_den <= i_denom;
        end else if (r_busy) begin
            // shift dividend bits out the top, quotient bits in the bottom
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// File: src/pidc_ctrl.sv
// Sequencer for the PID datapath: error, integral, divider launch, term products.
`default_nettype none

module pidc_ctrl
    import pidc_pkg::*;
#(
    parameter int CHUNKS = 2,
    parameter int CW     = 1
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_sts    i_sts,
    output t_cmd         o_cmd,
    output logic [CW-1:0] o_chunk
);

    localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

    t_state        r_state, n_state;
    t_term         r_term,  n_term;
    logic [CW-1:0] r_chunk, n_chunk;
    logic          r_zero,  n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= TERM_P;
            r_chunk <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            r_chunk <= n_chunk;
            r_zero  <= n_zero;
        end
    end

    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_chunk = r_chunk;
        n_zero  = r_zero;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                // zero elapsed time: emit zero, leave state alone
                if (i_sts.dt_zero) begin
                    n_zero  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_zero  = 1'b0;
                    n_state = S_INC;
                end
            end
            S_INC:   n_state = S_INTEG;
            S_INTEG: n_state = S_IMAG;
            S_IMAG: begin
                n_state = S_MUL;
                n_term  = TERM_P;
                n_chunk = LAST_CHUNK;
            end
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                if (r_chunk == '0) begin
                    n_state = S_TERM;
                end else begin
                    n_chunk = r_chunk - 1'b1;
                    n_state = S_MUL;
                end
            end
            S_TERM: begin
                n_chunk = LAST_CHUNK;
                case (r_term)
                    TERM_P: begin
                        n_term  = TERM_I;
                        n_state = S_MUL;
                    end
                    TERM_I: begin
                        n_term  = TERM_D;
                        n_state = S_DWAIT;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.term      = r_term;
        o_cmd.acc_first = (r_chunk == LAST_CHUNK);
        o_cmd.out_zero  = r_zero;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_ERR:   o_cmd.calc_err   = 1'b1;
            S_INC:   o_cmd.calc_inc   = 1'b1;
            S_INTEG: o_cmd.calc_integ = 1'b1;
            S_IMAG:  o_cmd.calc_imag  = 1'b1;
            S_MUL:   o_cmd.mul        = 1'b1;
            S_ACC:   o_cmd.acc_add    = 1'b1;
            S_TERM:  o_cmd.term_add   = 1'b1;
            S_OUT:   o_cmd.out_load   = i_sts.out_free;
            default: o_in_ready       = 1'b0;
        endcase
    end

    assign o_chunk = r_chunk;

    a_deriv_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_term == TERM_D) |-> i_sts.div_done)
        else $error("derivative product started before the quotient was ready");

    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ($past(r_state) == S_MUL))
        else $error("accumulate without a fresh product");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_sts.out_free) |=> (r_state == S_OUT))
        else $error("result dropped while output register was full");

endmodule

`default_nettype wire

// File: src/pidc_datapath.sv
// PID datapath: gains, error, saturating integral, shared multiplier, clamp, output register.
`default_nettype none

module pidc_datapath
    import pidc_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int INTEGRAL_WIDTH = 48,
    parameter int CHUNKS         = 2,
    parameter int CW             = 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [GAIN_W-1:0]       i_cfg_data,
    input  wire logic [SAMPLE_WIDTH-1:0] i_measured_value,
    input  wire logic [SAMPLE_WIDTH-1:0] i_target_value,
    input  wire logic [ELAPSED_W-1:0]    i_elapsed_us,
    input  wire t_cmd                    i_cmd,
    input  wire logic [CW-1:0]           i_chunk,
    output t_sts                         o_sts,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [DRIVE_W-1:0]           o_drive_value,
    output logic                         o_was_clamped
);

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;
    localparam int NUM_W  = DIFF_W + DERIV_FRAC;
    localparam int INC_W  = ERR_W + ELAPSED_W + 1;
    localparam int IW     = INTEGRAL_WIDTH;
    localparam int ISUM_W = ((IW > INC_W) ? IW : INC_W) + 1;
    localparam int MAG_W  = CHUNKS * CHUNK_W;
    localparam int ACC_W  = MAG_W + CHUNK_W;

    localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};

    // configuration, kept as magnitude and sign
    logic [GAIN_W-1:0] r_kp_mag, r_ki_mag, r_kd_mag;
    logic              r_kp_neg, r_ki_neg, r_kd_neg;
    logic [GAIN_W-1:0] cfg_mag;

    // captured sample
    logic signed [SAMPLE_WIDTH-1:0] r_meas, r_targ;
    logic [ELAPSED_W-1:0]           r_dt;

    // controller state
    logic signed [IW-1:0]    r_integ;
    logic signed [ERR_W-1:0] r_prev;

    // per-sample work registers
    logic signed [ERR_W-1:0] r_err;
    logic [ERR_W-1:0]        r_err_mag;
    logic [DIFF_W-1:0]       r_diff_mag;
    logic                    r_diff_neg;
    logic signed [INC_W-1:0] r_inc;
    logic [IW-1:0]           r_integ_mag;
    logic                    r_integ_neg;
    logic [2*CHUNK_W-1:0]    r_prod;
    logic [ACC_W-1:0]        r_acc;
    logic signed [SUM_W-1:0] r_sum;

    logic                     r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                     r_clamped;

    logic signed [ERR_W-1:0]  n_err;
    logic signed [DIFF_W-1:0] n_diff;
    logic signed [INC_W-1:0]  n_inc;
    logic signed [ISUM_W-1:0] n_isum;
    logic signed [IW-1:0]     n_integ;
    logic [MAG_W-1:0]         b_wide;
    logic [CHUNK_W-1:0]       b_chunk;
    logic [GAIN_W-1:0]        a_gain;
    logic [ACC_W-1:0]         n_acc;
    logic [ACC_W-1:0]         acc_sh;
    logic [TERM_W-1:0]        term_mag;
    logic                     term_neg;
    logic signed [TERM_W-1:0] term_val;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     out_free;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quot;

    assign cfg_mag = i_cfg_data[GAIN_W-1] ? (GAIN_W'(0) - i_cfg_data) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_mag <= '0;
            r_ki_mag <= '0;
            r_kd_mag <= '0;
            r_kp_neg <= 1'b0;
            r_ki_neg <= 1'b0;
            r_kd_neg <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GAIN_P: begin
                    r_kp_mag <= cfg_mag;
                    r_kp_neg <= i_cfg_data[GAIN_W-1];
                end
                REG_GAIN_I: begin
                    r_ki_mag <= cfg_mag;
                    r_ki_neg <= i_cfg_data[GAIN_W-1];
                end
                REG_GAIN_D: begin
                    r_kd_mag <= cfg_mag;
                    r_kd_neg <= i_cfg_data[GAIN_W-1];
                end
                default: begin
                    r_kp_mag <= r_kp_mag;
                end
            endcase
        end
    end

    // error and first difference
    assign n_err  = ERR_W'(r_targ) - ERR_W'(r_meas);
    assign n_diff = DIFF_W'(n_err) - DIFF_W'(r_prev);
    assign n_inc  = INC_W'(r_err) * INC_W'($signed({1'b0, r_dt}));

    // saturating integral update
    assign n_isum = ISUM_W'(r_integ) + ISUM_W'(r_inc);
    always_comb begin
        if (n_isum > ISUM_W'(I_MAX)) begin
            n_integ = I_MAX;
        end else if (n_isum < ISUM_W'(I_MIN)) begin
            n_integ = I_MIN;
        end else begin
            n_integ = IW'(n_isum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else begin
            if (i_cmd.calc_inc) begin
                r_prev <= r_err;
            end
            if (i_cmd.calc_integ) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_meas <= i_measured_value;
            r_targ <= i_target_value;
            r_dt   <= i_elapsed_us;
        end
        if (i_cmd.calc_err) begin
            r_err      <= n_err;
            r_err_mag  <= n_err[ERR_W-1] ? (ERR_W'(0) - n_err) : n_err;
            r_diff_mag <= n_diff[DIFF_W-1] ? (DIFF_W'(0) - n_diff) : n_diff;
            r_diff_neg <= n_diff[DIFF_W-1];
        end
        if (i_cmd.calc_inc) begin
            r_inc <= n_inc;
        end
        if (i_cmd.calc_imag) begin
            r_integ_mag <= r_integ[IW-1] ? (IW'(0) - r_integ) : r_integ;
            r_integ_neg <= r_integ[IW-1];
        end
        if (i_cmd.mul) begin
            r_prod <= a_gain * b_chunk;
        end
        if (i_cmd.acc_add) begin
            r_acc <= n_acc;
        end
        if (i_cmd.term_add) begin
            r_sum <= n_sum;
        end
    end

    pidc_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.calc_inc),
        .i_numer ({r_diff_mag, {DERIV_FRAC{1'b0}}}),
        .i_denom (r_dt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // operand select for the shared multiplier, most significant chunk first
    always_comb begin
        case (i_cmd.term)
            TERM_P: begin
                a_gain   = r_kp_mag;
                b_wide   = MAG_W'(r_err_mag);
                term_neg = r_kp_neg ^ r_err[ERR_W-1];
            end
            TERM_I: begin
                a_gain   = r_ki_mag;
                b_wide   = MAG_W'(r_integ_mag);
                term_neg = r_ki_neg ^ r_integ_neg;
            end
            TERM_D: begin
                a_gain   = r_kd_mag;
                b_wide   = MAG_W'(div_quot);
                term_neg = r_kd_neg ^ r_diff_neg;
            end
            default: begin
                a_gain   = '0;
                b_wide   = '0;
                term_neg = 1'b0;
            end
        endcase
    end

    assign b_chunk = b_wide[i_chunk*CHUNK_W +: CHUNK_W];
    assign n_acc   = (i_cmd.acc_first ? ACC_W'(0) : (r_acc << CHUNK_W)) + ACC_W'(r_prod);

    // derivative product carries an extra 2^-20 scale
    assign acc_sh   = (i_cmd.term == TERM_D) ? (r_acc >> DERIV_FRAC) : r_acc;
    assign term_mag = (acc_sh > ACC_W'(TERM_LIMIT)) ? TERM_W'(TERM_LIMIT) : TERM_W'(acc_sh);
    assign term_val = term_neg ? (TERM_W'(0) - $signed(term_mag)) : $signed(term_mag);
    assign n_sum    = ((i_cmd.term == TERM_P) ? SUM_W'(0) : r_sum) + SUM_W'(term_val);

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero) begin
                r_drive   <= '0;
                r_clamped <= 1'b0;
            end else if (r_sum > ONE_UNITS) begin
                r_drive   <= DRIVE_ONE;
                r_clamped <= 1'b1;
            end else if (r_sum < -ONE_UNITS) begin
                r_drive   <= -DRIVE_ONE;
                r_clamped <= 1'b1;
            end else begin
                // floor of the sum at Q2.14
                r_drive   <= r_sum[DRIVE_SHIFT+DRIVE_W-1:DRIVE_SHIFT];
                r_clamped <= 1'b0;
            end
        end
    end

    assign o_sts.dt_zero  = (r_dt == '0);
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_drive;
    assign o_was_clamped = r_clamped;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_drive <= DRIVE_ONE && r_drive >= -DRIVE_ONE))
        else $error("drive outside the clamp range");

    a_clamp_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_clamped) |-> (r_drive == DRIVE_ONE || r_drive == -DRIVE_ONE))
        else $error("clamp flag set off the rail");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && i_cmd.out_zero) |=> (r_drive == '0 && !r_clamped))
        else $error("zero elapsed time gave a nonzero drive");

endmodule

`default_nettype wire

// File: src/pid_controller_clamped.sv
// Top level of the PID controller with clamped Q2.14 drive output.
//
//  channel   direction  handshake                    beat contents
//  -------   ---------  ---------------------------  ------------------------------------
//  sample    in         i_in_valid / o_in_ready      measured, target (Q4.12), elapsed us
//  drive     out        o_out_valid / i_out_ready    drive (Q2.14), clamp flag
//  config    in         i_cfg_wr_en, no wait         index 0 kp, 1 ki, 2 kd (Q16.16)
//
//  One sample at a time. The derivative product waits in S_DWAIT for the serial
//  divider, one quotient bit per cycle over SAMPLE_WIDTH + 22 bits; the proportional
//  and integral products on the shared 32x32 multiplier overlap it. Zero elapsed
//  time skips the divider and the products.
//  Reset is synchronous and clears gains, integral and previous error.
//  A full output register holds its beat while the next sample runs; a result that
//  still finds it full waits in the last state and holds the input off.
`default_nettype none

module pid_controller_clamped
    import pidc_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int INTEGRAL_WIDTH = 48
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [GAIN_W-1:0]       i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] i_measured_value,
    input  wire logic [SAMPLE_WIDTH-1:0] i_target_value,
    input  wire logic [ELAPSED_W-1:0]    i_elapsed_us,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [DRIVE_W-1:0]           o_drive_value,
    output logic                         o_was_clamped
);

    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int NUM_W   = SAMPLE_WIDTH + 2 + DERIV_FRAC;
    localparam int MAG_A   = (INTEGRAL_WIDTH > NUM_W) ? INTEGRAL_WIDTH : NUM_W;
    localparam int MAG_RAW = (MAG_A > ERR_W) ? MAG_A : ERR_W;
    localparam int CHUNKS  = (MAG_RAW + CHUNK_W - 1) / CHUNK_W;
    localparam int CW      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [CW-1:0] chunk;

    pidc_ctrl #(
        .CHUNKS (CHUNKS),
        .CW     (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_chunk    (chunk)
    );

    pidc_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
        .CHUNKS         (CHUNKS),
        .CW             (CW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_measured_value (i_measured_value),
        .i_target_value   (i_target_value),
        .i_elapsed_us     (i_elapsed_us),
        .i_cmd            (cmd),
        .i_chunk          (chunk),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_value    (o_drive_value),
        .o_was_clamped    (o_was_clamped)
    );

endmodule

`default_nettype wire
